### hdl/shuffled_minimal_standard_rng_macros.svh
// Assertion macros for the shuffled minimal-standard generator.
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_MACROS_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_MACROS_SVH

`ifndef SYNTH
`define SMSR_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SMSR_ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define SMSR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SMSR_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define SMSR_ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define SMSR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

### hdl/smsr_pkg.sv
// Shared types, constants and the modular fold of the shuffled generator.
`timescale 1ns / 1ps
package smsr_pkg;

   typedef enum logic {
      REQ_SEED = 1'b0,
      REQ_DRAW = 1'b1
   } req_kind_type;

   localparam logic [30:0] GEN_MULT     = 31'd16807;
   localparam logic [30:0] GEN_MOD      = 31'h7FFF_FFFF;
   localparam int          WARMUP_STEPS = 8;
   localparam logic [33:0] RANGE_BIAS   = 34'd65529;

   // reduce a product below 2^46 modulo 2^31-1
   function automatic logic [30:0] gen_fold(input logic [62:0] prod);
      logic [31:0] sum;
      sum = {17'd0, prod[45:31]} + {1'b0, prod[30:0]};
      if (sum >= {1'b0, GEN_MOD}) begin
         sum = sum - {1'b0, GEN_MOD};
      end
      return sum[30:0];
   endfunction

endpackage

### hdl/smsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/shuffled_minimal_standard_rng.sv
// A draw runs DR_MUL, DR_FOLD, IX_EST, IX_FIX and TB_SWAP through one shared multiplier.
// A seed request, or a draw that must seed first, adds the warm-up and table-fill steps: each
// generator step is one multiply and one fold of the shared unit.
// One word in flight; the next waits until idle and the output register holds the result.
// Reset: synchronous, clears the generator state and the seeded flag; the table is
// written in full by every seeding before it is read.
`timescale 1ns / 1ps
module shuffled_minimal_standard_rng #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  smsr_pkg::req_kind_type      req_type,
   input  logic signed [31:0]          req_seed_value,
   input  logic signed [15:0]          req_range_min,
   input  logic signed [15:0]          req_range_max,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [30:0]                 rsp_raw_value,
   output logic signed [16:0]          rsp_ranged_value
);

   import smsr_pkg::*;

   `include "shuffled_minimal_standard_rng_macros.svh"

   localparam int IDXW     = $clog2(TABLE_DEPTH);
   localparam int STEPS    = WARMUP_STEPS + TABLE_DEPTH;
   localparam int CNTW     = $clog2(STEPS);
   localparam longint unsigned IdxDiv = 64'd1 + (64'(GEN_MOD) - 64'd1) / TABLE_DEPTH;
   localparam longint unsigned Recip  = (64'd1 << 31) / IdxDiv;
   localparam logic [CNTW-1:0] LAST_STEP = CNTW'(STEPS - 1);
   localparam logic [CNTW-1:0] WARM_END  = CNTW'(WARMUP_STEPS);

   typedef enum logic [2:0] {
      IDLE,
      SD_MUL,
      SD_FOLD,
      DR_MUL,
      DR_FOLD,
      IX_EST,
      IX_FIX,
      TB_SWAP
   } state_type;

   localparam state_type RG_DONE_UNUSED = IDLE;

   state_type state_ff, state_in;
   logic                 rg_done_ff, rg_done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [31:0]          s_ff, s_in;
   logic [30:0]          lcg_ff, lcg_in;
   logic [30:0]          last_ff, last_in;
   logic                 init_ff, init_in;
   logic [62:0]          product_ff, product_in;
   logic [IDXW:0]        q_ff, q_in;
   logic [IDXW-1:0]      idx_ff, idx_in;
   logic [31:0]          kmag_ff, kmag_in;
   logic                 kneg_ff, kneg_in;
   logic signed [15:0]   min_ff, min_in;
   logic signed [15:0]   max_ff, max_in;
   logic [30:0]          raw_out_ff, raw_out_in;
   logic signed [16:0]   ranged_out_ff, ranged_out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [31:0]          mul_a;
   logic [30:0]          mul_b;
   logic [30:0]          folded;
   logic [31:0]          seed_mag;
   logic [IDXW:0]        q_next;
   logic [IDXW:0]        idx_wide;
   logic signed [16:0]   span;
   logic signed [33:0]   k_wide;
   logic [16:0]          t_val;
   logic                 ram_wr_en;
   logic [IDXW-1:0]      ram_wr_addr;
   logic [30:0]          ram_wr_data;
   logic [30:0]          ram_rd_data;
   logic                 req_fire;
   logic                 out_free;

   smsr_ram #(
      .WIDTH (31),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == IDLE) && !rg_done_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign folded    = gen_fold(product_ff);
   assign seed_mag  = req_seed_value[31] ? (32'd0 - 32'(req_seed_value))
                                         : 32'(req_seed_value);
   assign q_next    = {1'b0, product_ff[31 +: IDXW]} + (IDXW+1)'(1);
   assign span      = {max_ff[15], max_ff} - {min_ff[15], min_ff};
   assign k_wide    = ({{17{span[16]}}, span} <<< 16) + $signed(RANGE_BIAS);
   assign t_val     = {1'b0, product_ff[62:47]};

   always_comb begin
      mul_a = 32'd0;
      mul_b = 31'd0;
      case (state_ff)
         SD_MUL: begin
            mul_a = s_ff;
            mul_b = GEN_MULT;
         end
         DR_MUL: begin
            mul_a = {1'b0, lcg_ff};
            mul_b = GEN_MULT;
         end
         DR_FOLD: begin
            mul_a = {1'b0, last_ff};
            mul_b = 31'(Recip);
         end
         IX_EST: begin
            mul_a = 32'(q_next);
            mul_b = 31'(IdxDiv);
         end
         TB_SWAP: begin
            mul_a = kmag_ff;
            mul_b = ram_rd_data;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 31'd0;
         end
      endcase
   end

   assign product_in = {31'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      state_in      = state_ff;
      rg_done_in    = 1'b0;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      lcg_in        = lcg_ff;
      last_in       = last_ff;
      init_in       = init_ff;
      q_in          = q_ff;
      idx_in        = idx_ff;
      kmag_in       = kmag_ff;
      kneg_in       = kneg_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      raw_out_in    = raw_out_ff;
      ranged_out_in = ranged_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = lcg_ff;
      idx_wide      = q_ff;

      // finish the ranged value and hold it until the output register is free
      if (rg_done_ff) begin
         if (out_free) begin
            raw_out_in    = last_ff;
            ranged_out_in = {min_ff[15], min_ff} +
                            (kneg_ff ? $signed(17'd0 - t_val) : $signed(t_val));
            rsp_valid_in  = 1'b1;
         end else begin
            rg_done_in = 1'b1;
         end
      end

      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               min_in = req_range_min;
               max_in = req_range_max;
               cnt_in = '0;
               if (req_type == REQ_SEED) begin
                  s_in     = (seed_mag == 32'd0) ? 32'd1 : seed_mag;
                  state_in = SD_MUL;
               end else if (!init_ff || lcg_ff == 31'd0 || last_ff == 31'd0) begin
                  s_in     = 32'd1;
                  state_in = SD_MUL;
               end else begin
                  state_in = DR_MUL;
               end
            end
         end
         SD_MUL: begin
            state_in = SD_FOLD;
         end
         SD_FOLD: begin
            s_in = {1'b0, folded};
            if (cnt_ff >= WARM_END) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDXW'(LAST_STEP - cnt_ff);
               ram_wr_data = folded;
            end
            if (cnt_ff == LAST_STEP) begin
               lcg_in   = folded;
               last_in  = folded;
               init_in  = 1'b1;
               state_in = DR_MUL;
            end else begin
               cnt_in   = cnt_ff + CNTW'(1);
               state_in = SD_MUL;
            end
         end
         DR_MUL: begin
            kmag_in  = k_wide[33] ? 32'(-k_wide) : k_wide[31:0];
            kneg_in  = k_wide[33];
            state_in = DR_FOLD;
         end
         DR_FOLD: begin
            lcg_in   = folded;
            state_in = IX_EST;
         end
         IX_EST: begin
            q_in     = q_next;
            state_in = IX_FIX;
         end
         IX_FIX: begin
            idx_wide = ({32'd0, last_ff} >= product_ff) ? q_ff : (q_ff - (IDXW+1)'(1));
            if (idx_wide >= (IDXW+1)'(TABLE_DEPTH)) begin
               idx_in = IDXW'(TABLE_DEPTH - 1);
            end else begin
               idx_in = idx_wide[IDXW-1:0];
            end
            state_in = TB_SWAP;
         end
         TB_SWAP: begin
            last_in     = ram_rd_data;
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = lcg_ff;
            rg_done_in  = 1'b1;
            state_in    = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rg_done_ff   <= 1'b0;
         cnt_ff       <= '0;
         lcg_ff       <= 31'd0;
         last_ff      <= 31'd0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rg_done_ff   <= rg_done_in;
         cnt_ff       <= cnt_in;
         lcg_ff       <= lcg_in;
         last_ff      <= last_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff          <= s_in;
      product_ff    <= (rg_done_ff && !out_free) ? product_ff : product_in;
      q_ff          <= q_in;
      idx_ff        <= idx_in;
      kmag_ff       <= kmag_in;
      kneg_ff       <= kneg_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      raw_out_ff    <= raw_out_in;
      ranged_out_ff <= ranged_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = raw_out_ff;
   assign rsp_ranged_value = ranged_out_ff;

   `SMSR_ASSERT_IMPLIES(a_swap_seeded, clock, reset, state_ff == TB_SWAP, init_ff, "draw on unseeded table")
   `SMSR_ASSERT_IMPLIES(a_swap_index, clock, reset, state_ff == TB_SWAP, 32'(idx_ff) < 32'(TABLE_DEPTH), "table index out of range")
   `SMSR_ASSERT_IMPLIES(a_step_count, clock, reset, state_ff == SD_FOLD, cnt_ff <= LAST_STEP, "seed step count overrun")
   `SMSR_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != IDLE, "accepted word left block idle")
   `SMSR_ASSERT_IMPLIES(a_load_source, clock, reset, $rose(rsp_valid_ff), $past(rg_done_ff), "result raised without ranging")
   `SMSR_ASSERT_HOLDS(a_done_idle, clock, reset, !rg_done_ff || state_ff == IDLE || state_ff == RG_DONE_UNUSED, "ranging overlaps work")

endmodule

### dv/minstd_shuffle_checker.sv
// Checker for the shuffled minimal-standard generator: predicts each response word and compares it.
`timescale 1ns / 1ps
module minstd_shuffle_checker #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  smsr_pkg::req_kind_type req_type,
   input  logic signed [31:0]     req_seed_value,
   input  logic signed [15:0]     req_range_min,
   input  logic signed [15:0]     req_range_max,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [30:0]            rsp_raw_value,
   input  logic signed [16:0]     rsp_ranged_value,
   output int                     mismatch_count,
   output int                     draws_pending
);
   import smsr_pkg::*;

   localparam longint unsigned SLOT_DIV = 1 + (64'(GEN_MOD) - 1) / TABLE_DEPTH;

   typedef struct packed {
      logic [30:0]        raw;
      logic signed [16:0] ranged;
   } draw_word_type;

   draw_word_type expected_draws[$];
   logic [30:0] gen_state;
   logic [30:0] shuffled_out;
   logic [30:0] shuffle_slots[TABLE_DEPTH];
   bit          seeded;
   int          fail_tally = 0;

   function automatic logic [30:0] minstd_next(input logic [31:0] s);
      longint unsigned prod;
      prod = 64'(s) * 64'(GEN_MULT);
      prod = prod % 64'(GEN_MOD);
      return prod[30:0];
   endfunction

   task automatic reseed_slots(input logic [31:0] mag);
      logic [31:0] s;
      int          k;
      s = (mag == 32'd0) ? 32'd1 : mag;
      for (k = 0; k < WARMUP_STEPS; k++) begin
         s = {1'b0, minstd_next(s)};
      end
      for (k = TABLE_DEPTH - 1; k >= 0; k--) begin
         s = {1'b0, minstd_next(s)};
         shuffle_slots[k] = s[30:0];
      end
      gen_state    = s[30:0];
      shuffled_out = shuffle_slots[0];
      seeded       = 1'b1;
   endtask

   task automatic draw_next();
      longint unsigned slot;
      gen_state = minstd_next({1'b0, gen_state});
      slot      = 64'(shuffled_out) / SLOT_DIV;
      if (slot >= TABLE_DEPTH) begin
         slot = TABLE_DEPTH - 1;
      end
      shuffled_out        = shuffle_slots[slot];
      shuffle_slots[slot] = gen_state;
   endtask

   function automatic logic signed [16:0] scale_to_range(input logic signed [15:0] lo,
                                                         input logic signed [15:0] hi,
                                                         input logic [30:0]        raw);
      longint          span_k;
      longint unsigned mag;
      longint          t;
      span_k = (longint'(hi) - longint'(lo)) * 65536 + longint'(RANGE_BIAS);
      mag    = (span_k < 0) ? 64'(-span_k) : 64'(span_k);
      t      = longint'((mag * 64'(raw)) >> 47);
      if (span_k < 0) begin
         t = -t;
      end
      t = t + longint'(lo);
      return t[16:0];
   endfunction

   task automatic note_mismatch(input string what, input longint want, input longint got);
      fail_tally++;
      if (fail_tally <= 10) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      draw_word_type want;
      logic [31:0]   magnitude;
      if (reset) begin
         expected_draws.delete();
         gen_state    = '0;
         shuffled_out = '0;
         seeded       = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               note_mismatch("unexpected word raw_value", -1, longint'(rsp_raw_value));
            end else begin
               want = expected_draws.pop_front();
               if (rsp_raw_value !== want.raw) begin
                  note_mismatch("raw_value", longint'(want.raw), longint'(rsp_raw_value));
               end
               if (rsp_ranged_value !== want.ranged) begin
                  note_mismatch("ranged_value", longint'($signed(want.ranged)),
                                longint'(rsp_ranged_value));
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_SEED) begin
               magnitude = req_seed_value[31] ? (~req_seed_value + 32'd1) : req_seed_value;
               reseed_slots(magnitude);
            end else if (!seeded || gen_state == '0 || shuffled_out == '0) begin
               reseed_slots(32'd1);
            end
            draw_next();
            want.raw    = shuffled_out;
            want.ranged = scale_to_range(req_range_min, req_range_max, shuffled_out);
            expected_draws.push_back(want);
         end
      end
      mismatch_count <= fail_tally;
      draws_pending  <= expected_draws.size();
   end

endmodule

### dv/shuffled_minimal_standard_rng_tb.sv
// Testbench top for the shuffled minimal-standard generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module shuffled_minimal_standard_rng_tb;
   import smsr_pkg::*;

   localparam int DEPTH       = 32;
   localparam int RANDOM_WORDS = 382;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   req_kind_type       req_type       = REQ_SEED;
   logic signed [31:0] req_seed_value = '0;
   logic signed [15:0] req_range_min  = '0;
   logic signed [15:0] req_range_max  = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [30:0]        rsp_raw_value;
   logic signed [16:0] rsp_ranged_value;
   int                 mismatch_count;
   int                 draws_pending;
   int                 idle_pct  = 0;
   int                 stall_pct = 0;

   shuffled_minimal_standard_rng #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_seed_value  (req_seed_value),
      .req_range_min   (req_range_min),
      .req_range_max   (req_range_max),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_raw_value   (rsp_raw_value),
      .rsp_ranged_value(rsp_ranged_value)
   );

   minstd_shuffle_checker #(
      .TABLE_DEPTH(DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_seed_value  (req_seed_value),
      .req_range_min   (req_range_min),
      .req_range_max   (req_range_max),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_raw_value   (rsp_raw_value),
      .rsp_ranged_value(rsp_ranged_value),
      .mismatch_count  (mismatch_count),
      .draws_pending   (draws_pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_word(input req_kind_type kind, input logic [31:0] seed,
                            input logic signed [15:0] lo, input logic signed [15:0] hi);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_seed_value <= seed;
      req_range_min  <= lo;
      req_range_max  <= hi;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h8000_0001;
         4:       return $urandom_range(1, 1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic pick_range(output logic signed [15:0] lo, output logic signed [15:0] hi);
      int base;
      int reach;
      case ($urandom_range(9))
         4: begin
            lo = -16'sd32768;
            hi = 16'sd32767;
         end
         5: begin
            lo = 16'sd32767;
            hi = -16'sd32768;
         end
         6: begin
            lo = 16'($urandom);
            hi = lo;
         end
         7, 8, 9: begin
            lo    = 16'($urandom);
            base  = int'(lo);
            reach = base + int'($urandom_range(0, 200));
            hi    = (reach > 32767) ? 16'sd32767 : reach[15:0];
         end
         default: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
      endcase
   endtask

   initial begin
      int                 idle_by_phase[4];
      int                 stall_by_phase[4];
      int                 phase;
      int                 n;
      req_kind_type       kind;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      idle_by_phase  = '{0, 59, 0, 33};
      stall_by_phase = '{0, 0, 59, 33};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(REQ_DRAW, $urandom, 16'sd0, 16'sd100);
      send_word(REQ_SEED, 32'd0, -16'sd32768, 16'sd32767);
      send_word(REQ_DRAW, $urandom, 16'sd32767, -16'sd32768);
      send_word(REQ_DRAW, $urandom, -16'sd32768, -16'sd32768);
      send_word(REQ_DRAW, $urandom, 16'sd32767, 16'sd32767);
      send_word(REQ_SEED, 32'd1, 16'sd0, 16'sd0);
      send_word(REQ_SEED, 32'h7FFF_FFFF, -16'sd32768, 16'sd32767);
      send_word(REQ_DRAW, 32'hFFFF_FFFF, -16'sd32768, 16'sd32767);
      send_word(REQ_DRAW, 32'd0, 16'sd0, 16'sd1);
      send_word(REQ_SEED, 32'h8000_0000, -16'sd32768, 16'sd32767);
      send_word(REQ_DRAW, $urandom, -16'sd1, 16'sd0);
      send_word(REQ_SEED, 32'h8000_0001, 16'sd0, -16'sd1);
      send_word(REQ_DRAW, $urandom, 16'sd32767, -16'sd32768);
      send_word(REQ_SEED, 32'h7FFF_FFFE, 16'sd1000, 16'sd2000);
      send_word(REQ_SEED, 32'hFFFF_FFFF, -16'sd5, 16'sd5);
      send_word(REQ_SEED, 32'sd1, -16'sd32768, 16'sd32767);
      for (n = 0; n < 6; n++) begin
         send_word(REQ_DRAW, $urandom, -16'sd32768, 16'sd32767);
      end

      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         for (n = 0; n < RANDOM_WORDS; n++) begin
            kind = ($urandom_range(99) < 8) ? REQ_SEED : REQ_DRAW;
            pick_range(lo, hi);
            send_word(kind, (kind == REQ_SEED) ? pick_seed() : $urandom, lo, hi);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (draws_pending != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/smsr_pkg.sv
hdl/smsr_ram.sv
hdl/shuffled_minimal_standard_rng.sv
dv/minstd_shuffle_checker.sv
dv/shuffled_minimal_standard_rng_tb.sv
